### rtl/deq_pkg.sv
// Shared action codes, status codes and fixed field widths of the deque core.
package deq_pkg;

   localparam int ACTION_BITS = 3;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 5;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_INS_REAR  = 3'd0,
      ACT_REM_FRONT = 3'd1,
      ACT_INS_FRONT = 3'd2,
      ACT_REM_REAR  = 3'd3,
      ACT_DUMP      = 3'd4
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

### rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/double_ended_queue_core.sv
// Top level of the deque core: ring pointers, read sequencer and result register.
//
// A bounded double-ended queue of signed words kept in a ring of DEPTH RAM slots.
// Request channel (req_): one word per handshake carries an action and a value.
// Insert rear/front writes the slot in the accept cycle; the single result
// (status ok, or full when rejected) appears in the cycle after accept, so
// inserts sustain one word per cycle while the response is not stalled.
// Remove front/rear reads the RAM in the accept cycle; the removed word passes
// through the RAM read register into the result register, and no new request
// is taken until it has been loaded there.
// Dump streams every stored word front to rear, one per cycle while the
// response is not stalled, the final one carrying last_flag.
// Empty removals and dumps give one result with status empty, in the cycle after
// accept. Unused action codes are accepted and give no result.
// Response channel (rsp_): a stall holds the result register; the RAM output
// register holds the next dumped word, so nothing is lost and the stream resumes
// at full rate once the stall drops.
// Reset clears the pointers, count and result valid. Slot contents are not
// cleared; only written slots are ever read.
module double_ended_queue_core #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic        [deq_pkg::ACTION_BITS-1:0] req_action,
   input  logic signed [deq_pkg::VALUE_BITS-1:0]  req_item_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [deq_pkg::VALUE_BITS-1:0]  rsp_out_value,
   output logic        [deq_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                                   rsp_last_flag,
   output logic        [deq_pkg::OCC_BITS-1:0]    rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = CW + 1;
   localparam int VB = deq_pkg::VALUE_BITS;
   localparam int OB = deq_pkg::OCC_BITS;

   function automatic logic [AW-1:0] wrap_sum(input logic [AW-1:0] a,
                                              input logic [CW-1:0] b);
      logic [IW-1:0] s;
      s = IW'(a) + IW'(b);
      if (s >= IW'(DEPTH)) begin
         s = s - IW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] a);
      return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] a);
      return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
   endfunction

   function automatic logic [OB-1:0] occ_of(input logic [CW-1:0] c);
      logic [CW+OB-1:0] e;
      e = {{OB{1'b0}}, c};
      return e[OB-1:0];
   endfunction

   logic [AW-1:0]        front_ff, front_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic                 pend_ff, pend_in;
   logic                 pend_last_ff, pend_last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0]        rsp_value_ff, rsp_value_in;
   logic [deq_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [OB-1:0]        rsp_occ_ff, rsp_occ_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;
   logic [WORD_BITS+VB-1:0] in_ext, out_ext;

   logic                 accept, busy, can_load, drain_load, issue_more;
   logic                 full, empty, imm_load;
   deq_pkg::status_type  imm_status;
   logic [AW-1:0]        rear_idx, last_idx;

   assign in_ext  = {{WORD_BITS{req_item_value[VB-1]}}, req_item_value};
   assign wr_data = in_ext[WORD_BITS-1:0];
   assign out_ext = {{VB{1'b0}}, rd_data};

   assign busy       = pend_ff || (rem_ff != '0);
   assign req_stall  = busy || (rsp_valid_ff && rsp_stall);
   assign accept     = req_valid && !req_stall;
   assign can_load   = !rsp_valid_ff || !rsp_stall;
   assign drain_load = pend_ff && can_load;
   assign issue_more = (rem_ff != '0) && (!pend_ff || drain_load);
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign rear_idx   = wrap_sum(front_ff, count_ff);
   assign last_idx   = wrap_sum(front_ff, count_ff - 1'b1);

   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      wr_en        = 1'b0;
      wr_addr      = rear_idx;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      imm_load     = 1'b0;
      imm_status   = deq_pkg::ST_OK;
      if (accept) begin
         case (req_action)
            deq_pkg::ACT_INS_REAR: begin
               imm_load = 1'b1;
               if (full) begin
                  imm_status = deq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::ACT_INS_FRONT: begin
               imm_load = 1'b1;
               if (full) begin
                  imm_status = deq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = prev_idx(front_ff);
                  front_in = prev_idx(front_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::ACT_REM_FRONT: begin
               if (empty) begin
                  imm_load   = 1'b1;
                  imm_status = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en        = 1'b1;
                  front_in     = next_idx(front_ff);
                  count_in     = count_ff - 1'b1;
                  pend_in      = 1'b1;
                  pend_last_in = 1'b1;
               end
            end
            deq_pkg::ACT_REM_REAR: begin
               if (empty) begin
                  imm_load   = 1'b1;
                  imm_status = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = last_idx;
                  count_in     = count_ff - 1'b1;
                  pend_in      = 1'b1;
                  pend_last_in = 1'b1;
               end
            end
            deq_pkg::ACT_DUMP: begin
               if (empty) begin
                  imm_load   = 1'b1;
                  imm_status = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en        = 1'b1;
                  rd_ptr_in    = next_idx(front_ff);
                  rem_in       = count_ff - 1'b1;
                  pend_in      = 1'b1;
                  pend_last_in = (count_ff == CW'(1));
               end
            end
            default: begin
            end
         endcase
      end else begin
         if (drain_load) begin
            pend_in = 1'b0;
         end
         if (issue_more) begin
            rd_en        = 1'b1;
            rd_addr      = rd_ptr_ff;
            rd_ptr_in    = next_idx(rd_ptr_ff);
            rem_in       = rem_ff - 1'b1;
            pend_in      = 1'b1;
            pend_last_in = (rem_ff == CW'(1));
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (imm_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = imm_status;
         rsp_last_in   = 1'b1;
         rsp_occ_in    = occ_of(count_in);
      end else if (drain_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = out_ext[VB-1:0];
         rsp_status_in = deq_pkg::ST_OK;
         rsp_last_in   = pend_last_ff;
         rsp_occ_in    = occ_of(count_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   deq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last_flag = rsp_last_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

### rtl/deq_check.sv
// Port-level assertion checker for the deque core, bound to the top level.
module deq_check (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [deq_pkg::VALUE_BITS-1:0]  rsp_out_value,
   input logic        [deq_pkg::STATUS_BITS-1:0] rsp_status,
   input logic                                   rsp_last_flag,
   input logic        [deq_pkg::OCC_BITS-1:0]    rsp_occupancy
);

   a_empty_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == deq_pkg::ST_EMPTY) |->
         rsp_last_flag && (rsp_occupancy == '0) && (rsp_out_value == '0))
      else $error("empty answer with data, occupancy or open stream");

   a_full_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == deq_pkg::ST_FULL) |->
         rsp_last_flag && (rsp_out_value == '0))
      else $error("full rejection with data or open stream");

   a_dump_middle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_flag |->
         (rsp_status == deq_pkg::ST_OK) && (rsp_occupancy != '0))
      else $error("non-final word of a dump from an empty queue or with bad status");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_out_value) && $stable(rsp_status) &&
         $stable(rsp_last_flag) && $stable(rsp_occupancy))
      else $error("stalled response word changed");

endmodule

bind double_ended_queue_core deq_check u_deq_check (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_value (rsp_out_value),
   .rsp_status    (rsp_status),
   .rsp_last_flag (rsp_last_flag),
   .rsp_occupancy (rsp_occupancy)
);
